FILE: rtl/core/wnh_pkg.sv
// ============================================================================
// wnh_pkg: shared types and constants of the waypoint graph store
// Sizes, field layout of one input beat, mode codes, sequencer states and
// the structs that travel between the sequencer, the distance unit and
// the memories.
// ============================================================================
package wnh_pkg;

    // Table sizes
    localparam int MAX_NODES = 1024;
    localparam int MAX_LINKS = 8;

    // Field widths
    localparam int NODE_W  = 10;
    localparam int SLOT_W  = 3;
    localparam int LCNT_W  = 4;
    localparam int NCNT_W  = 11;
    localparam int PREV_W  = 11;
    localparam int COORD_W = 32;
    localparam int POS_W   = 3 * COORD_W;
    localparam int LADDR_W = NODE_W + SLOT_W;

    // Distance arithmetic: |a-b| fits 32 bits, its square 64, the sum of three 66
    localparam int ABS_W  = 32;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int DIST_W = SQ_W + 2;

    // Step count of the square-accumulate unit at which the sum is final
    localparam logic [2:0] SQ_DONE_STEP = 3'd5;

    // Stream widths
    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    typedef enum logic [1:0] {
        MODE_POS  = 2'd0,
        MODE_LINK = 2'd1,
        MODE_NEAR = 2'd2,
        MODE_NEXT = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NQ_RD,
        ST_NQ_START,
        ST_NQ_CALC,
        ST_CH_RD,
        ST_CH_CNT,
        ST_CH_LRD,
        ST_CH_CHK,
        ST_OUT
    } state_t;

    typedef struct packed {
        mode_t                     mode;
        logic [NODE_W-1:0]         node_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [SLOT_W-1:0]         link_slot;
        logic [NODE_W-1:0]         link_target;
        logic [LCNT_W-1:0]         link_count;
        logic signed [PREV_W-1:0]  previous_node;
        logic [SLOT_W-1:0]         start_offset;
    } item_t;

    // Request to the square-accumulate unit: query point and node position
    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic signed [COORD_W-1:0] qz;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } sq_req_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] sqsum;
    } sq_rsp_t;

    // Write and read controls of the three memories
    typedef struct packed {
        logic               pos_we;
        logic [NODE_W-1:0]  pos_waddr;
        logic [POS_W-1:0]   pos_wdata;
        logic [NODE_W-1:0]  pos_raddr;
        logic               link_we;
        logic [LADDR_W-1:0] link_waddr;
        logic [NODE_W-1:0]  link_wdata;
        logic [LADDR_W-1:0] link_raddr;
        logic               lc_we;
        logic [NODE_W-1:0]  lc_waddr;
        logic [LCNT_W-1:0]  lc_wdata;
        logic [NODE_W-1:0]  lc_raddr;
    } mem_ctrl_t;

endpackage

FILE: rtl/core/wnh_ram.sv
// ============================================================================
// wnh_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ============================================================================
module wnh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/wnh_sqdist.sv
// ============================================================================
// wnh_sqdist: shared square-accumulate unit
// Takes the absolute coordinate differences at start, then runs one
// 32x32 multiplier three times and sums the squares into an exact 66-bit
// distance. The sum is final when the step counter reaches SQ_DONE_STEP.
// ============================================================================
module wnh_sqdist import wnh_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  sq_req_t req,
    output sq_rsp_t rsp
);

    logic [ABS_W-1:0]  ad_reg [3];
    logic [2:0]        step_reg, step_next;
    logic              pv_reg, pv_next;
    logic [ABS_W-1:0]  op;
    logic [SQ_W-1:0]   prod_reg, prod_next;
    logic [DIST_W-1:0] sum_reg;

    function automatic logic [ABS_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? ABS_W'(-d) : ABS_W'(d);
    endfunction

    // Pick the multiplier operand for this step
    always_comb begin
        unique case (step_reg)
            3'd1:    op = ad_reg[0];
            3'd2:    op = ad_reg[1];
            3'd3:    op = ad_reg[2];
            default: op = '0;
        endcase
        prod_next = SQ_W'(op) * SQ_W'(op);
        pv_next   = (step_reg >= 3'd1) && (step_reg <= 3'd3);
    end

    // Advance the step counter
    always_comb begin
        step_next = step_reg;
        if (req.start) begin
            step_next = 3'd1;
        end else if (step_reg == SQ_DONE_STEP) begin
            step_next = '0;
        end else if (step_reg != '0) begin
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            pv_reg   <= 1'b0;
        end else begin
            step_reg <= step_next;
            pv_reg   <= pv_next;
        end
    end

    // Capture differences, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (req.start) begin
            ad_reg[0] <= abs_diff(req.qx, req.px);
            ad_reg[1] <= abs_diff(req.qy, req.py);
            ad_reg[2] <= abs_diff(req.qz, req.pz);
            sum_reg   <= '0;
        end else if (pv_reg) begin
            sum_reg <= sum_reg + DIST_W'(prod_reg);
        end
        prod_reg <= prod_next;
    end

    assign rsp.done  = (step_reg == SQ_DONE_STEP);
    assign rsp.sqsum = sum_reg;

endmodule

FILE: rtl/core/wnh_seq.sv
// ============================================================================
// wnh_seq: command sequencer of the waypoint store
// Takes one beat at a time, drives the memory ports, walks the nodes for
// a nearest query through the shared distance unit, walks a node's links
// for a next-hop choice, and holds the result until it is taken.
// ============================================================================
module wnh_seq import wnh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  item_t             s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [NODE_W-1:0] m_node,
    input  logic [NCNT_W-1:0] node_count,
    input  logic [POS_W-1:0]  pos_rdata,
    input  logic [NODE_W-1:0] link_rdata,
    input  logic [LCNT_W-1:0] lc_rdata,
    output sq_req_t           sq_req,
    input  sq_rsp_t           sq_rsp,
    output mem_ctrl_t         mem
);

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic [NODE_W-1:0] n_reg, n_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic              found_reg, found_next;
    logic [NODE_W-1:0] res_reg, res_next;
    logic [LCNT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [LCNT_W-1:0] k_reg, k_next;
    logic              s_accept;
    logic [NCNT_W-1:0] cand_ext;

    // Start offset modulo link count, by repeated subtraction on 4 bits
    function automatic logic [SLOT_W-1:0] slot_mod(
        input logic [SLOT_W-1:0] s,
        input logic [LCNT_W-1:0] c
    );
        logic [LCNT_W-1:0] r;
        r = LCNT_W'(s);
        for (int i = 0; i < MAX_LINKS; i++) begin
            if (r >= c) begin
                r = r - c;
            end
        end
        return SLOT_W'(r);
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (state_reg == ST_OUT);
    assign m_found  = found_reg;
    assign m_node   = res_reg;
    assign cand_ext = {1'b0, link_rdata};

    // Distance request: query point held from the beat, position from memory
    assign sq_req.start = (state_reg == ST_NQ_START);
    assign sq_req.qx    = item_reg.pos_x;
    assign sq_req.qy    = item_reg.pos_y;
    assign sq_req.qz    = item_reg.pos_z;
    assign sq_req.px    = pos_rdata[COORD_W-1:0];
    assign sq_req.py    = pos_rdata[2*COORD_W-1:COORD_W];
    assign sq_req.pz    = pos_rdata[3*COORD_W-1:2*COORD_W];

    // Memory ports
    always_comb begin
        mem.pos_we     = s_accept && (s_item.mode == MODE_POS);
        mem.pos_waddr  = s_item.node_index;
        mem.pos_wdata  = {s_item.pos_z, s_item.pos_y, s_item.pos_x};
        mem.pos_raddr  = n_reg;
        mem.link_we    = s_accept && (s_item.mode == MODE_LINK);
        mem.link_waddr = {s_item.node_index, s_item.link_slot};
        mem.link_wdata = s_item.link_target;
        mem.link_raddr = {item_reg.node_index, slot_reg};
        mem.lc_we      = s_accept && (s_item.mode == MODE_LINK);
        mem.lc_waddr   = s_item.node_index;
        mem.lc_wdata   = (s_item.link_count > LCNT_W'(MAX_LINKS)) ?
                         LCNT_W'(MAX_LINKS) : s_item.link_count;
        mem.lc_raddr   = item_reg.node_index;
        // Clearing pass owns the link count write port after reset
        if (state_reg == ST_CLEAR) begin
            mem.lc_we    = 1'b1;
            mem.lc_waddr = clr_reg;
            mem.lc_wdata = '0;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        clr_next   = clr_reg;
        n_next     = n_reg;
        best_next  = best_reg;
        found_next = found_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + NODE_W'(1);
                if (clr_reg == NODE_W'(MAX_NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    item_next = s_item;
                    unique case (s_item.mode)
                        MODE_POS, MODE_LINK: begin
                            state_next = ST_IDLE;
                        end
                        MODE_NEAR: begin
                            n_next     = '0;
                            found_next = 1'b0;
                            res_next   = '0;
                            state_next = (node_count == '0) ? ST_OUT : ST_NQ_RD;
                        end
                        MODE_NEXT: begin
                            found_next = 1'b0;
                            res_next   = '0;
                            state_next = ST_CH_RD;
                        end
                    endcase
                end
            end
            ST_NQ_RD: begin
                state_next = ST_NQ_START;
            end
            ST_NQ_START: begin
                state_next = ST_NQ_CALC;
            end
            ST_NQ_CALC: begin
                if (sq_rsp.done) begin
                    // Keep the strictly smaller distance: lowest index wins ties
                    if (!found_reg || (sq_rsp.sqsum < best_reg)) begin
                        found_next = 1'b1;
                        best_next  = sq_rsp.sqsum;
                        res_next   = n_reg;
                    end
                    if (({1'b0, n_reg} + NCNT_W'(1)) == node_count) begin
                        state_next = ST_OUT;
                    end else begin
                        n_next     = n_reg + NODE_W'(1);
                        state_next = ST_NQ_RD;
                    end
                end
            end
            ST_CH_RD: begin
                state_next = ST_CH_CNT;
            end
            ST_CH_CNT: begin
                if (({1'b0, item_reg.node_index} >= node_count) || (lc_rdata == '0)) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next   = lc_rdata;
                    slot_next  = slot_mod(item_reg.start_offset, lc_rdata);
                    k_next     = '0;
                    state_next = ST_CH_LRD;
                end
            end
            ST_CH_LRD: begin
                state_next = ST_CH_CHK;
            end
            ST_CH_CHK: begin
                if ((cand_ext < node_count) &&
                    ((cand_ext != item_reg.previous_node) || (cnt_reg == LCNT_W'(1)))) begin
                    found_next = 1'b1;
                    res_next   = link_rdata;
                    state_next = ST_OUT;
                end else if ((k_reg + LCNT_W'(1)) == cnt_reg) begin
                    state_next = ST_OUT;
                end else begin
                    k_next     = k_reg + LCNT_W'(1);
                    slot_next  = ((LCNT_W'(slot_reg) + LCNT_W'(1)) == cnt_reg) ?
                                 '0 : slot_reg + SLOT_W'(1);
                    state_next = ST_CH_LRD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            found_reg <= 1'b0;
            res_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            found_reg <= found_next;
            res_reg   <= res_next;
        end
    end

    // Working payload
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        n_reg    <= n_next;
        best_reg <= best_next;
        cnt_reg  <= cnt_next;
        slot_reg <= slot_next;
        k_reg    <= k_next;
    end

endmodule

FILE: rtl/core/waypoint_nearest_and_next_hop.sv
// Nearest query: goes straight to the result when node_count is 0; otherwise each node
//   costs a position read, a distance start and a run of the shared multiplier.
// Next-hop choice: a link count read, then a slot read and check per link tried.
// Writes go to memory as the beat is accepted. One item at a time; s_tready is low until the result is taken.
// Reset: a clearing pass over all MAX_NODES entries zeroes the link counts with s_tready low;
//   node_count resets to zero and the config channel is taken throughout.
// ============================================================================
// waypoint_nearest_and_next_hop: waypoint graph store, top level
// Holds node positions, link slots and link counts in memories, answers
// nearest-node queries and next-hop choices.
// ============================================================================
module waypoint_nearest_and_next_hop import wnh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // node_count
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [NCNT_W-1:0]     cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // node_index, pos_x, pos_y, pos_z, link_slot, link_target, link_count,
    // previous_node, start_offset, then zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_node, then zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    // found
    output logic [M_TUSER_W-1:0]  m_tuser
);

    logic [NCNT_W-1:0] node_count_reg, node_count_next;
    item_t             s_item;
    mem_ctrl_t         mem;
    sq_req_t           sq_req;
    sq_rsp_t           sq_rsp;
    logic [POS_W-1:0]  pos_rdata;
    logic [NODE_W-1:0] link_rdata;
    logic [LCNT_W-1:0] lc_rdata;
    logic              m_found;
    logic [NODE_W-1:0] m_node;

    // Unpack the input beat
    assign s_item.mode          = mode_t'(s_tuser);
    assign s_item.node_index    = s_tdata[9:0];
    assign s_item.pos_x         = s_tdata[41:10];
    assign s_item.pos_y         = s_tdata[73:42];
    assign s_item.pos_z         = s_tdata[105:74];
    assign s_item.link_slot     = s_tdata[108:106];
    assign s_item.link_target   = s_tdata[118:109];
    assign s_item.link_count    = s_tdata[122:119];
    assign s_item.previous_node = s_tdata[133:123];
    assign s_item.start_offset  = s_tdata[136:134];

    // Node count register, saturated to the table size
    assign cfg_ready       = 1'b1;
    assign node_count_next = (cfg_data > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            node_count_reg <= node_count_next;
        end
    end

    wnh_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_found    (m_found),
        .m_node     (m_node),
        .node_count (node_count_reg),
        .pos_rdata  (pos_rdata),
        .link_rdata (link_rdata),
        .lc_rdata   (lc_rdata),
        .sq_req     (sq_req),
        .sq_rsp     (sq_rsp),
        .mem        (mem)
    );

    wnh_sqdist u_sqdist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .rsp     (sq_rsp)
    );

    // Positions, packed z:y:x
    wnh_ram #(.WIDTH(POS_W), .DEPTH(MAX_NODES)) u_pos_ram (
        .aclk  (aclk),
        .we    (mem.pos_we),
        .waddr (mem.pos_waddr),
        .wdata (mem.pos_wdata),
        .raddr (mem.pos_raddr),
        .rdata (pos_rdata)
    );

    // Link slots, addressed node:slot
    wnh_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES * MAX_LINKS)) u_link_ram (
        .aclk  (aclk),
        .we    (mem.link_we),
        .waddr (mem.link_waddr),
        .wdata (mem.link_wdata),
        .raddr (mem.link_raddr),
        .rdata (link_rdata)
    );

    // Link counts, cleared by the pass after reset
    wnh_ram #(.WIDTH(LCNT_W), .DEPTH(MAX_NODES)) u_lc_ram (
        .aclk  (aclk),
        .we    (mem.lc_we),
        .waddr (mem.lc_waddr),
        .wdata (mem.lc_wdata),
        .raddr (mem.lc_raddr),
        .rdata (lc_rdata)
    );

    // Pack the result beat
    assign m_tdata = {{(M_TDATA_W - NODE_W){1'b0}}, m_node};
    assign m_tuser = m_found;

endmodule

FILE: rtl/core/wnh_checker.sv
// ============================================================================
// wnh_checker: port-level checks of the waypoint store
// Watches the stream ports of the top level and flags broken result
// beats and acceptance that overlaps an item in flight.
// ============================================================================
module wnh_checker import wnh_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // Hold a stalled result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Not found carries a zero node
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found result with nonzero node");

    // No new beat while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // A query blocks the input on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == MODE_NEAR || s_tuser == MODE_NEXT) |=> !s_tready)
        else $error("input ready right after a query");

    // A write gives no result and leaves the input ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == MODE_POS || s_tuser == MODE_LINK)
        |=> s_tready && !m_tvalid)
        else $error("write beat produced a result or stalled the input");

endmodule

bind waypoint_nearest_and_next_hop wnh_checker u_wnh_checker (.*);
